// ===== rtl/core/gbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfp_pkg: shared types and constants of the GNSS binary frame parser
// Frame layout constants, configuration register indexes, message kinds and
// the constant tables used to reduce time of week modulo one day.
// ----------------------------------------------------------------------------
`default_nettype none

package gbfp_pkg;

    // Frame layout
    localparam logic [7:0]  PREAMBLE       = 8'h55;
    localparam logic [9:0]  FRAME_OVERHEAD = 10'd8;
    localparam logic [9:0]  POS_MIN_LEN    = 10'd22;
    localparam logic [9:0]  TIME_MIN_LEN   = 10'd16;

    // Offsets within a frame
    localparam logic [8:0]  OFF_TYPE_LO    = 9'd1;
    localparam logic [8:0]  OFF_TYPE_HI    = 9'd2;
    localparam logic [8:0]  OFF_LENGTH     = 9'd5;
    localparam logic [8:0]  OFF_FIELD_FIRST = 9'd6;
    localparam logic [8:0]  OFF_FIELD_LAST  = 9'd21;
    localparam logic [8:0]  OFF_MIN_LAST    = 9'd7;

    // Configuration registers
    localparam logic [15:0] POS_ID_RESET   = 16'd515;
    localparam logic [15:0] TIME_ID_RESET  = 16'd256;
    localparam logic        CFG_POS_ID     = 1'b0;
    localparam logic        CFG_TIME_ID    = 1'b1;

    typedef enum logic {
        KIND_POSITION = 1'b0,
        KIND_TIME     = 1'b1
    } t_msg_kind;

    // One day in milliseconds
    localparam logic [26:0] DAY_MS    = 27'd86400000;
    localparam logic [63:0] DAY_MS_64 = 64'd86400000;

    // Day reduction: the top bits of the 32-bit value select a multiple of
    // one day just below it; what remains is under two days.
    localparam int TOW_SHIFT = 26;
    localparam int TOW_IDX_W = 32 - TOW_SHIFT;
    localparam int TOW_DEPTH = 1 << TOW_IDX_W;

    typedef logic [32:0] t_tow_tab [TOW_DEPTH];

    function automatic t_tow_tab build_tow_tab(input logic plus_day);
        t_tow_tab    tab;
        logic [63:0] quo;
        for (int i = 0; i < TOW_DEPTH; i++) begin
            quo    = (64'(i) << TOW_SHIFT) / DAY_MS_64;
            tab[i] = 33'(quo * DAY_MS_64 + (plus_day ? DAY_MS_64 : 64'd0));
        end
        return tab;
    endfunction

    localparam t_tow_tab TOW_BASE    = build_tow_tab(1'b0);
    localparam t_tow_tab TOW_BASE_HI = build_tow_tab(1'b1);

endpackage

`default_nettype wire

// ===== rtl/core/gnss_binary_frame_parser.sv =====
// Path: the last byte of a frame is registered in the capture stage, then
//   the day reduction of its time of week is registered in the output stage.
// Throughput: one byte per cycle; upstream is stalled only when both result
//   stages hold data that downstream has not taken.
// Reset: synchronous, active low; parser hunts for a preamble, both result
//   stages empty, type registers return to 515 (position) and 256 (time).
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser: byte-serial parser for binary GNSS frames
// Collects position and time frames, extracts time of week (modulo one day),
// north/east/down offsets and the nanosecond part; flags short frames.
// ----------------------------------------------------------------------------
`default_nettype none

module gnss_binary_frame_parser
    import gbfp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // configuration write port
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,

    // byte input
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_rx_byte,

    // result output
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_msg_kind,
    output logic [26:0]             o_time_of_week_ms,
    output logic signed [31:0]      o_north_mm,
    output logic signed [31:0]      o_east_mm,
    output logic signed [31:0]      o_down_mm,
    output logic signed [31:0]      o_nanosecond_part,
    output logic                    o_fields_complete
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [15:0]        r_pos_id;
    logic [15:0]        r_time_id;

    logic               r_in_frame;
    logic [8:0]         r_offset;
    logic [15:0]        r_type;
    logic [7:0]         r_len;
    logic [31:0]        r_word [4];

    // capture stage
    logic               r_s1_valid;
    t_msg_kind          r_s1_kind;
    logic [31:0]        r_s1_tow_raw;
    logic [31:0]        r_s1_north;
    logic [31:0]        r_s1_east;
    logic [31:0]        r_s1_down;
    logic [31:0]        r_s1_nsec;
    logic               r_s1_complete;

    // output stage
    logic               r_out_valid;
    t_msg_kind          r_out_kind;
    logic [26:0]        r_out_tow;
    logic [31:0]        r_out_north;
    logic [31:0]        r_out_east;
    logic [31:0]        r_out_down;
    logic [31:0]        r_out_nsec;
    logic               r_out_complete;

    // ------------------------------------------------------------------
    // Next values
    // ------------------------------------------------------------------
    logic [15:0]        n_type;
    logic [7:0]         n_len;
    logic [31:0]        n_word [4];
    logic [8:0]         n_offset;
    logic [8:0]         rel;
    logic [9:0]         frame_len;
    logic               frame_last;
    logic               pos_hit;
    logic               time_hit;

    logic               out_ready;
    logic               s1_ready;
    logic               s1_adv;
    logic               accept;
    logic               s1_load;

    logic [TOW_IDX_W-1:0] tow_idx;
    logic [31:0]        tow_diff_lo;
    logic [32:0]        tow_diff_hi;
    logic [26:0]        tow_mod;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_ready = !r_out_valid || !i_stall;
    assign s1_adv    = r_s1_valid && out_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_stall   = !s1_ready;
    assign accept    = i_valid && s1_ready;

    // ------------------------------------------------------------------
    // Byte capture: merge the incoming byte into the frame fields
    // ------------------------------------------------------------------
    always_comb begin
        n_type   = r_type;
        n_len    = r_len;
        n_word   = r_word;
        n_offset = r_offset + 9'd1;
        rel      = r_offset - OFF_FIELD_FIRST;
        if (r_offset == OFF_TYPE_LO) begin
            n_type = {8'h00, i_rx_byte};
        end else if (r_offset == OFF_TYPE_HI) begin
            n_type[15:8] = i_rx_byte;
        end else if (r_offset == OFF_LENGTH) begin
            n_len = i_rx_byte;
        end else if (r_offset >= OFF_FIELD_FIRST && r_offset <= OFF_FIELD_LAST) begin
            n_word[rel[3:2]][{rel[1:0], 3'b000} +: 8] = i_rx_byte;
        end
    end

    // last byte once offset 7 is reached and the declared length is covered
    assign frame_len  = FRAME_OVERHEAD + {2'b00, n_len};
    assign frame_last = (r_offset >= OFF_MIN_LAST) &&
                        (({1'b0, r_offset} + 10'd1) >= frame_len);

    // position type wins when both registers hold the same number
    assign pos_hit  = (n_type == r_pos_id);
    assign time_hit = !pos_hit && (n_type == r_time_id);

    assign s1_load  = accept && r_in_frame && frame_last && (pos_hit || time_hit);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_id  <= POS_ID_RESET;
            r_time_id <= TIME_ID_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_POS_ID:  r_pos_id  <= i_cfg_data;
                CFG_TIME_ID: r_time_id <= i_cfg_data;
                default:     r_pos_id  <= r_pos_id;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame tracking
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_offset   <= '0;
        end else if (accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == PREAMBLE) begin
                    r_in_frame <= 1'b1;
                    r_offset   <= OFF_TYPE_LO;
                end
            end else if (frame_last) begin
                r_in_frame <= 1'b0;
                r_offset   <= '0;
            end else begin
                r_offset   <= n_offset;
            end
        end
    end

    // field words start from zero so bytes past a short frame read as zero
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_in_frame) begin
                r_type <= '0;
                r_len  <= '0;
                for (int w = 0; w < 4; w++) begin
                    r_word[w] <= '0;
                end
            end else begin
                r_type <= n_type;
                r_len  <= n_len;
                for (int w = 0; w < 4; w++) begin
                    r_word[w] <= n_word[w];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Capture stage: pick the fields of the finished frame
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            if (pos_hit) begin
                r_s1_kind     <= KIND_POSITION;
                r_s1_tow_raw  <= n_word[0];
                r_s1_north    <= n_word[1];
                r_s1_east     <= n_word[2];
                r_s1_down     <= n_word[3];
                r_s1_nsec     <= '0;
                r_s1_complete <= (frame_len >= POS_MIN_LEN);
            end else begin
                r_s1_kind     <= KIND_TIME;
                r_s1_tow_raw  <= {n_word[1][15:0], n_word[0][31:16]};
                r_s1_north    <= '0;
                r_s1_east     <= '0;
                r_s1_down     <= '0;
                r_s1_nsec     <= {n_word[2][15:0], n_word[1][31:16]};
                r_s1_complete <= (frame_len >= TIME_MIN_LEN);
            end
        end
    end

    // ------------------------------------------------------------------
    // Day reduction: subtract a table multiple, then at most one more day
    // ------------------------------------------------------------------
    assign tow_idx     = r_s1_tow_raw[31:TOW_SHIFT];
    assign tow_diff_lo = r_s1_tow_raw - TOW_BASE[tow_idx][31:0];
    assign tow_diff_hi = {1'b0, r_s1_tow_raw} - TOW_BASE_HI[tow_idx];
    assign tow_mod     = tow_diff_hi[32] ? tow_diff_lo[26:0] : tow_diff_hi[26:0];

    // ------------------------------------------------------------------
    // Output stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_kind     <= r_s1_kind;
            r_out_tow      <= tow_mod;
            r_out_north    <= r_s1_north;
            r_out_east     <= r_s1_east;
            r_out_down     <= r_s1_down;
            r_out_nsec     <= r_s1_nsec;
            r_out_complete <= r_s1_complete;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_msg_kind        = r_out_kind;
    assign o_time_of_week_ms = r_out_tow;
    assign o_north_mm        = r_out_north;
    assign o_east_mm         = r_out_east;
    assign o_down_mm         = r_out_down;
    assign o_nanosecond_part = r_out_nsec;
    assign o_fields_complete = r_out_complete;

endmodule

`default_nettype wire

// ===== rtl/core/gbfp_checker.sv =====
// ----------------------------------------------------------------------------
// gbfp_checker: port-level checks of the GNSS binary frame parser
// Watches the result channel for held transactions and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfp_checker
    import gbfp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_valid,
    input  wire logic               i_stall,
    input  wire logic               o_msg_kind,
    input  wire logic [26:0]        o_time_of_week_ms,
    input  wire logic signed [31:0] o_north_mm,
    input  wire logic signed [31:0] o_east_mm,
    input  wire logic signed [31:0] o_down_mm,
    input  wire logic signed [31:0] o_nanosecond_part,
    input  wire logic               o_fields_complete
);

    // a stalled result stays valid with its time of week, kind and flag unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_time_of_week_ms) &&
        $stable(o_msg_kind) && $stable(o_fields_complete))
        else $error("result changed while stalled");

    // time of week is always reduced below one day
    a_tow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_time_of_week_ms < DAY_MS)
        else $error("time of week not reduced modulo one day");

    // time frames carry no position
    a_time_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_msg_kind == KIND_TIME |->
        o_north_mm == 0 && o_east_mm == 0 && o_down_mm == 0)
        else $error("position fields set on a time frame");

    // position frames carry no nanosecond part
    a_pos_no_nsec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_msg_kind == KIND_POSITION |-> o_nanosecond_part == 0)
        else $error("nanosecond part set on a position frame");

endmodule

bind gnss_binary_frame_parser gbfp_checker u_gbfp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_msg_kind        (o_msg_kind),
    .o_time_of_week_ms (o_time_of_week_ms),
    .o_north_mm        (o_north_mm),
    .o_east_mm         (o_east_mm),
    .o_down_mm         (o_down_mm),
    .o_nanosecond_part (o_nanosecond_part),
    .o_fields_complete (o_fields_complete)
);

`default_nettype wire
